// ===== rtl/core/bgtpf_pkg.sv =====
// Package: shared types, codes and defaults of the background tile pixel fetch unit.
`default_nettype none

package bgtpf_pkg;

  localparam int VRAM_BYTES_DEF   = 8192;
  localparam int SCREEN_WIDTH_DEF = 160;

  localparam int ADDR_W  = 13;
  localparam int CIDX_W  = 3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SCROLL_Y         = 3'd0,
    CFG_SCROLL_X         = 3'd1,
    CFG_MAP_SELECT_HIGH  = 3'd2,
    CFG_PATTERN_UNSIGNED = 3'd3,
    CFG_BG_PALETTE       = 3'd4
  } cfg_idx_t;

  localparam logic [7:0] BG_PALETTE_RST = 8'd252;

  // Two high offset bits of both tile maps (0x9800 and 0x9C00 from 0x8000).
  localparam logic [1:0] MAP_BASE_HI = 2'b11;

endpackage

`default_nettype wire

// ===== rtl/core/background_tile_pixel_fetch_unit.sv =====
// Top level: background tile pixel fetch unit with banked video memory.
`default_nettype none

// Write words store one byte of video memory per cycle while in_ready is high.
// Render words: the tile index read and the pattern row read share the single
// read port of each of the two video memory banks (even and odd bytes), so a
// new word is taken only once the last tile index read has moved to stage 2.
// The result is registered; the output register lets the next word enter
// while a result waits. Render words with a column at or beyond SCREEN_WIDTH,
// and write words, produce no result. Memory contents are undefined until
// written; configuration is to be written only while idle.
module background_tile_pixel_fetch_unit
  import bgtpf_pkg::*;
#(
  parameter int VRAM_BYTES   = VRAM_BYTES_DEF,
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [7:0]        cfg_data,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_op,
  input  wire logic [ADDR_W-1:0] in_mem_address,
  input  wire logic [7:0]        in_mem_data,
  input  wire logic [7:0]        in_screen_line,
  input  wire logic [7:0]        in_screen_column,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_shade,
  output logic [1:0]             out_color_index,
  output logic [7:0]             out_line,
  output logic [7:0]             out_column
);

  localparam int BANK_DEPTH = (VRAM_BYTES + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // configuration
  logic [7:0] scroll_y_r, scroll_x_r, bg_palette_r;
  logic       map_high_r, pat_unsigned_r;

  // stage 1: tile index read outstanding
  logic       s1_valid_r;
  logic [2:0] s1_xlo_r, s1_row_r;
  logic       s1_xsel_r;
  logic [7:0] s1_line_r, s1_col_r;

  // stage 2: pattern row read outstanding
  logic       s2_valid_r;
  logic [2:0] s2_xlo_r;
  logic [7:0] s2_line_r, s2_col_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_shade_r, out_color_r;
  logic [7:0] out_line_r, out_col_r;

  // memory
  logic [7:0] mem_even [BANK_DEPTH];
  logic [7:0] mem_odd  [BANK_DEPTH];
  logic [7:0] rd_even_r, rd_odd_r;

  logic              in_acc, col_ok, tile_rd, pat_rd, rd_en, mem_we;
  logic              out_free, s2_adv, s2_free, s1_adv;
  logic [7:0]        in_ys, in_xs, tile_id;
  logic [ADDR_W-2:0] map_word, pat_word, rd_word;
  logic [BANK_AW-1:0] rd_idx, wr_idx;
  logic [1:0]        color;
  logic [2:0]        bit_sel;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || out_ready;
  assign s2_adv   = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r && s2_free;
  assign in_acc   = in_valid && in_ready;

  assign in_ys   = in_screen_line + scroll_y_r;
  assign in_xs   = in_screen_column + scroll_x_r;
  assign col_ok  = {1'b0, in_screen_column} < 9'(SCREEN_WIDTH);
  assign tile_rd = in_acc && (op_t'(in_op) == OP_RENDER) && col_ok;
  assign mem_we  = in_acc && (op_t'(in_op) == OP_WRITE);
  assign pat_rd  = s1_adv;
  assign rd_en   = tile_rd || pat_rd;

  assign map_word = {MAP_BASE_HI, map_high_r, in_ys[7:3], in_xs[7:4]};
  assign tile_id  = s1_xsel_r ? rd_odd_r : rd_even_r;
  assign pat_word = {!pat_unsigned_r && !tile_id[7], tile_id, s1_row_r};
  assign rd_word  = tile_rd ? map_word : pat_word;
  assign rd_idx   = BANK_AW'(rd_word);
  assign wr_idx   = BANK_AW'(in_mem_address[ADDR_W-1:1]);

  assign bit_sel = ~s2_xlo_r;
  assign color   = {rd_odd_r[bit_sel], rd_even_r[bit_sel]};

  always_ff @(posedge clk) begin
    if (mem_we && !in_mem_address[0]) begin
      mem_even[wr_idx] <= in_mem_data;
    end
    if (mem_we && in_mem_address[0]) begin
      mem_odd[wr_idx] <= in_mem_data;
    end
    if (rd_en) begin
      rd_even_r <= mem_even[rd_idx];
      rd_odd_r  <= mem_odd[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_y_r     <= '0;
      scroll_x_r     <= '0;
      map_high_r     <= 1'b0;
      pat_unsigned_r <= 1'b1;
      bg_palette_r   <= BG_PALETTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCROLL_Y:         scroll_y_r     <= cfg_data;
        CFG_SCROLL_X:         scroll_x_r     <= cfg_data;
        CFG_MAP_SELECT_HIGH:  map_high_r     <= cfg_data[0];
        CFG_PATTERN_UNSIGNED: pat_unsigned_r <= cfg_data[0];
        CFG_BG_PALETTE:       bg_palette_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tile_rd) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tile_rd) begin
      s1_xlo_r  <= in_xs[2:0];
      s1_xsel_r <= in_xs[3];
      s1_row_r  <= in_ys[2:0];
      s1_line_r <= in_screen_line;
      s1_col_r  <= in_screen_column;
    end
    if (s1_adv) begin
      s2_xlo_r  <= s1_xlo_r;
      s2_line_r <= s1_line_r;
      s2_col_r  <= s1_col_r;
    end
    if (s2_adv) begin
      out_color_r <= color;
      out_shade_r <= {bg_palette_r[{color, 1'b1}], bg_palette_r[{color, 1'b0}]};
      out_line_r  <= s2_line_r;
      out_col_r   <= s2_col_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shade       = out_shade_r;
  assign out_color_index = out_color_r;
  assign out_line        = out_line_r;
  assign out_column      = out_col_r;

  a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(tile_rd && pat_rd))
    else $error("tile and pattern reads collide");

  a_no_write_mid: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && s1_valid_r))
    else $error("memory write between tile and pattern read");

  a_tile_then_s1: assert property (@(posedge clk) disable iff (!rst_n)
    tile_rd |=> s1_valid_r)
    else $error("tile read lost");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_adv) |=> (s2_valid_r && $stable(s2_line_r) && $stable(rd_even_r)))
    else $error("stalled pixel lost");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the background tile pixel fetch unit: directed and random words, per-pixel check.
`timescale 1ns / 1ps

module tb
  import bgtpf_pkg::*;
();

  localparam int VRAM_BYTES   = VRAM_BYTES_DEF;
  localparam int SCREEN_WIDTH = SCREEN_WIDTH_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [ADDR_W-1:0] MAP_LOW_OFS    = 13'h1800;
  localparam logic [ADDR_W-1:0] MAP_HIGH_OFS   = 13'h1C00;
  localparam logic [ADDR_W-1:0] SIGNED_PAT_OFS = 13'h0800;

  typedef struct packed {
    logic [1:0] shade;
    logic [1:0] color;
    logic [7:0] line;
    logic [7:0] column;
  } pixel_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [7:0]        cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              in_op;
  logic [ADDR_W-1:0] in_mem_address;
  logic [7:0]        in_mem_data;
  logic [7:0]        in_screen_line;
  logic [7:0]        in_screen_column;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_shade;
  logic [1:0]        out_color_index;
  logic [7:0]        out_line;
  logic [7:0]        out_column;

  logic [7:0] vram_copy [VRAM_BYTES];
  bit         vram_loaded [VRAM_BYTES];
  logic [7:0] cur_scroll_y;
  logic [7:0] cur_scroll_x;
  logic       cur_map_high;
  logic       cur_pat_unsigned;
  logic [7:0] cur_palette;

  pixel_t pixels_due [$];
  int     errors;
  int     words_sent;
  int     cycles;
  bit     idle_on;

  background_tile_pixel_fetch_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_mem_address   (in_mem_address),
    .in_mem_data      (in_mem_data),
    .in_screen_line   (in_screen_line),
    .in_screen_column (in_screen_column),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shade        (out_shade),
    .out_color_index  (out_color_index),
    .out_line         (out_line),
    .out_column       (out_column)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] map_entry(logic [7:0] line, logic [7:0] col);
    logic [7:0] ys;
    logic [7:0] xs;
    ys = line + cur_scroll_y;
    xs = col + cur_scroll_x;
    return (cur_map_high ? MAP_HIGH_OFS : MAP_LOW_OFS) + {3'd0, ys[7:3], xs[7:3]};
  endfunction

  function automatic logic [ADDR_W-1:0] row_entry(logic [7:0] tile, logic [7:0] line);
    logic [7:0] ys;
    ys = line + cur_scroll_y;
    if (cur_pat_unsigned) return {1'b0, tile, ys[2:0], 1'b0};
    return SIGNED_PAT_OFS + {1'b0, ~tile[7], tile[6:0], ys[2:0], 1'b0};
  endfunction

  function automatic pixel_t fetch_pixel(logic [7:0] line, logic [7:0] col);
    logic [7:0]        xs;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic [2:0]        bitpos;
    logic [ADDR_W-1:0] row;
    pixel_t            px;
    xs = col + cur_scroll_x;
    bitpos = 3'd7 - xs[2:0];
    row = row_entry(vram_copy[map_entry(line, col)], line);
    lo = vram_copy[row];
    hi = vram_copy[row + 1'b1];
    px.color = {hi[bitpos], lo[bitpos]};
    px.shade = cur_palette[{px.color, 1'b0} +: 2];
    px.line = line;
    px.column = col;
    return px;
  endfunction

  task automatic send_word(op_t op, logic [ADDR_W-1:0] addr, logic [7:0] data,
                           logic [7:0] line, logic [7:0] col);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_mem_address   <= addr;
    in_mem_data      <= data;
    in_screen_line   <= line;
    in_screen_column <= col;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (op == OP_WRITE) begin
      vram_copy[addr] = data;
      vram_loaded[addr] = 1'b1;
    end else if (col < SCREEN_WIDTH) begin
      pixels_due.push_back(fetch_pixel(line, col));
    end
  endtask

  task automatic write_byte(logic [ADDR_W-1:0] addr, logic [7:0] data);
    send_word(OP_WRITE, addr, data, 8'($urandom), 8'($urandom));
  endtask

  task automatic render(logic [7:0] line, logic [7:0] col);
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] r;
    if (col < SCREEN_WIDTH) begin
      m = map_entry(line, col);
      if (!vram_loaded[m]) write_byte(m, 8'($urandom));
      r = row_entry(vram_copy[m], line);
      if (!vram_loaded[r]) write_byte(r, 8'($urandom));
      if (!vram_loaded[r + 1'b1]) write_byte(r + 1'b1, 8'($urandom));
    end
    send_word(OP_RENDER, ADDR_W'($urandom), 8'($urandom), line, col);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SCROLL_Y:         cur_scroll_y = value;
      CFG_SCROLL_X:         cur_scroll_x = value;
      CFG_MAP_SELECT_HIGH:  cur_map_high = value[0];
      CFG_PATTERN_UNSIGNED: cur_pat_unsigned = value[0];
      CFG_BG_PALETTE:       cur_palette = value;
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [7:0] sy, logic [7:0] sx, logic mh, logic pu,
                               logic [7:0] pal);
    settle();
    write_reg(CFG_SCROLL_Y, sy);
    write_reg(CFG_SCROLL_X, sx);
    write_reg(CFG_MAP_SELECT_HIGH, {7'd0, mh});
    write_reg(CFG_PATTERN_UNSIGNED, {7'd0, pu});
    write_reg(CFG_BG_PALETTE, pal);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_registers();
    set_registers(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic random_words(int n);
    int target;
    int pick;
    target = words_sent + n;
    while (words_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        write_byte(ADDR_W'($urandom), 8'($urandom));
      else if (pick == 1)
        render(8'($urandom_range(0, 255)), 8'($urandom_range(SCREEN_WIDTH, 255)));
      else if (pick == 2)
        render(8'($urandom_range(0, 255)), 8'($urandom_range(0, SCREEN_WIDTH - 1)));
      else
        render(8'($urandom_range(0, 143)), 8'($urandom_range(0, SCREEN_WIDTH - 1)));
    end
  endtask

  task automatic test_edges();
    write_byte(13'h0000, 8'hFF);
    write_byte(13'h1FFF, 8'h00);
    write_byte(13'h1800, 8'h00);
    render(8'd0, 8'd0);
    render(8'd255, 8'd159);
    render(8'd143, 8'd80);
    render(8'd200, 8'd7);
    render(8'd10, 8'd160);
    render(8'd255, 8'd255);
  endtask

  task automatic test_register_sweep();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_registers(8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00);
        1: set_registers(8'h00, 8'h00, 1'b0, 1'b1, 8'hFF);
        2: set_registers(8'h00, 8'h00, 1'b0, 1'b0, 8'hE4);
        default: random_registers();
      endcase
      random_words(190);
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    random_registers();
    random_words(120);
  endtask

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_pixel
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: pixel expected none actual line %0d column %0d",
                 $time, out_line, out_column);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        check_field("shade", int'(want.shade), int'(out_shade));
        check_field("color_index", int'(want.color), int'(out_color_index));
        check_field("line", int'(want.line), int'(out_line));
        check_field("column", int'(want.column), int'(out_column));
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_op            = OP_WRITE;
    in_mem_address   = '0;
    in_mem_data      = '0;
    in_screen_line   = '0;
    in_screen_column = '0;
    idle_on          = 1'b1;
    errors           = 0;
    words_sent       = 0;
    cycles           = 0;
    cur_scroll_y     = 8'd0;
    cur_scroll_x     = 8'd0;
    cur_map_high     = 1'b0;
    cur_pat_unsigned = 1'b1;
    cur_palette      = BG_PALETTE_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_edges();
    test_register_sweep();
    test_full_rate();
    settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bgtpf_pkg.sv
rtl/core/background_tile_pixel_fetch_unit.sv
dv/tb.sv
